// ----- hdl/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and a function for the base64 decoder
// Holds the character classifier and the word carried between the front end
// and the output stage.
// ----------------------------------------------------------------------------
package b64d_pkg;

   // Default number of entries in the queue between front end and back end.
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   // Result of classifying one character.
   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   // One queue word: a complete 24-bit group, or an error marker.
   typedef struct packed {
      logic        is_error;
      logic [23:0] group;
   } job_type;

   // Maps a character to its sextet; the pad character counts as zero.
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      logic [7:0] d;
      s.valid = 1'b1;
      s.value = 6'd0;
      d       = 8'd0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d       = c - CHAR_UPPER_A;
         s.value = d[5:0];
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d       = c - CHAR_LOWER_A + 8'd26;
         s.value = d[5:0];
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         d       = c - CHAR_DIGIT_0 + 8'd52;
         s.value = d[5:0];
      end else if (c == CHAR_PLUS) begin
         s.value = 6'd62;
      end else if (c == CHAR_SLASH) begin
         s.value = 6'd63;
      end else if (c == CHAR_PAD) begin
         s.value = 6'd0;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

// ----- hdl/b64d_front.sv -----
// ----------------------------------------------------------------------------
// b64d_front: character intake and group assembly
// Classifies each character, gathers sextets and hands complete groups or
// error markers to the queue.
// ----------------------------------------------------------------------------
module b64d_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_char_in,
   output logic              push_valid,
   output b64d_pkg::job_type push_job,
   input  logic              queue_full
);

   logic [17:0] acc_ff, acc_in;
   logic [1:0]  pos_ff, pos_in;
   b64d_pkg::sextet_type sextet;
   logic accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign sextet    = b64d_pkg::sextet_of(req_char_in);

   // Next accumulator state and queue push for the accepted character.
   always_comb begin
      acc_in            = acc_ff;
      pos_in            = pos_ff;
      push_valid        = 1'b0;
      push_job.is_error = 1'b0;
      push_job.group    = {acc_ff, sextet.value};
      if (accept) begin
         if (!sextet.valid) begin
            push_valid        = 1'b1;
            push_job.is_error = 1'b1;
            push_job.group    = 24'd0;
            acc_in            = 18'd0;
            pos_in            = 2'd0;
         end else if (pos_ff != 2'd3) begin
            acc_in = {acc_ff[11:0], sextet.value};
            pos_in = pos_ff + 2'd1;
         end else begin
            push_valid = 1'b1;
            acc_in     = 18'd0;
            pos_in     = 2'd0;
         end
      end
   end

   // Group state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 18'd0;
         pos_ff <= 2'd0;
      end else begin
         acc_ff <= acc_in;
         pos_ff <= pos_in;
      end
   end

endmodule

// ----- hdl/b64d_queue.sv -----
// ----------------------------------------------------------------------------
// b64d_queue: small queue between front end and back end
// A circular buffer of group words with a fill count.
// ----------------------------------------------------------------------------
module b64d_queue #(
   parameter int unsigned DEPTH = b64d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  b64d_pkg::job_type push_job,
   output logic              full,
   output logic              pop_valid,
   output b64d_pkg::job_type pop_job,
   input  logic              pop
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   b64d_pkg::job_type slots_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic do_push, do_pop;

   assign full      = (count_ff == FULL_COUNT);
   assign pop_valid = (count_ff != '0);
   assign pop_job   = slots_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // Storage write.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- hdl/b64d_back.sv -----
// ----------------------------------------------------------------------------
// b64d_back: byte output stage
// Takes group words from the queue and presents their bytes one per cycle,
// while rsp_ready is high, from an output register.
// ----------------------------------------------------------------------------
module b64d_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  b64d_pkg::job_type pop_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_data_byte,
   output logic              rsp_last,
   output logic              rsp_bad_char
);

   logic        valid_ff, valid_in;
   logic [7:0]  data_ff, data_in;
   logic        last_ff, last_in;
   logic        bad_ff, bad_in;
   logic [15:0] rest_ff, rest_in;
   logic [1:0]  remain_ff, remain_in;
   logic        advance;

   assign advance = !valid_ff || rsp_ready;

   // Choose the next word to show: the rest of the current group first.
   always_comb begin
      valid_in  = valid_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      bad_in    = bad_ff;
      rest_in   = rest_ff;
      remain_in = remain_ff;
      pop       = 1'b0;
      if (advance) begin
         if (remain_ff != 2'd0) begin
            valid_in  = 1'b1;
            data_in   = rest_ff[15:8];
            last_in   = (remain_ff == 2'd1);
            bad_in    = 1'b0;
            rest_in   = {rest_ff[7:0], 8'd0};
            remain_in = remain_ff - 2'd1;
         end else if (pop_valid) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            if (pop_job.is_error) begin
               data_in = 8'd0;
               last_in = 1'b1;
               bad_in  = 1'b1;
            end else begin
               data_in   = pop_job.group[23:16];
               last_in   = 1'b0;
               bad_in    = 1'b0;
               rest_in   = pop_job.group[15:0];
               remain_in = 2'd2;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         remain_ff <= 2'd0;
      end else begin
         valid_ff  <= valid_in;
         remain_ff <= remain_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      bad_ff  <= bad_in;
      rest_ff <= rest_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_data_byte = data_ff;
   assign rsp_last      = last_ff;
   assign rsp_bad_char  = bad_ff;

endmodule

// ----- hdl/base64_decoder_top.sv -----
// ----------------------------------------------------------------------------
// base64_decoder_top: streaming base64 decoder
// Decodes one base64 character per word into bytes, three per group of four.
// ----------------------------------------------------------------------------
// The decoder accepts one character every cycle while its queue has room.
// Each fourth character of a group, counting pads as zero, yields three bytes,
// most significant first, the third marked last; a character outside the
// alphabet yields one error word and drops the partial group. Bytes leave one
// per cycle while rsp_ready is high, from an output register behind the group
// queue; the output stage outpaces the intake, so a steady stream of valid
// text is taken at one character per cycle, and the QUEUE_DEPTH-entry group
// queue absorbs output stalls.
module base64_decoder_top #(
   parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last,
   output logic       rsp_bad_char
);

   logic              push_valid;
   b64d_pkg::job_type push_job;
   logic              queue_full;
   logic              pop_valid;
   b64d_pkg::job_type pop_job;
   logic              pop;

   // Character intake.
   b64d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_char_in (req_char_in),
      .push_valid  (push_valid),
      .push_job    (push_job),
      .queue_full  (queue_full)
   );

   // Group queue.
   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop        (pop)
   );

   // Byte output.
   b64d_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_job       (pop_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_byte (rsp_data_byte),
      .rsp_last      (rsp_last),
      .rsp_bad_char  (rsp_bad_char)
   );

endmodule

// ----- tb/sv/base64_decoder_top_tb.sv -----
// ----------------------------------------------------------------------------
// base64_decoder_top_tb: self-checking bench for the streaming base64 decoder
// Feeds text characters through the request channel, predicts the decoded
// bytes and error words, and compares every response word field by field
// while both sides stall in random bursts.
// ----------------------------------------------------------------------------
module base64_decoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_CHARS = 150;
   localparam int CALM_TAIL    = 40;
   localparam int DRAIN_CYCLES = 32;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_REPORTS  = 10;
   localparam string ALPHABET  =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // One expected response word.
   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
      logic       bad;
   } decoded_word_type;

   // Tracks the decoder's group state and the response words still owed.
   class b64_byte_scoreboard;
      decoded_word_type due_words[$];
      logic [17:0]      sextets;
      logic [1:0]       held;
      int               failures;
      int               chars_seen;
      int               groups_seen;
      int               bad_seen;
      int               words_seen;

      function new();
         sextets     = '0;
         held        = '0;
         failures    = 0;
         chars_seen  = 0;
         groups_seen = 0;
         bad_seen    = 0;
         words_seen  = 0;
      endfunction

      // Returns 1 with the sextet value for alphabet characters and the pad.
      function bit lookup(input logic [7:0] c, output logic [5:0] v);
         v = '0;
         if (c >= b64d_pkg::CHAR_UPPER_A && c <= b64d_pkg::CHAR_UPPER_Z) begin
            v = 6'(c - b64d_pkg::CHAR_UPPER_A);
         end else if (c >= b64d_pkg::CHAR_LOWER_A && c <= b64d_pkg::CHAR_LOWER_Z) begin
            v = 6'(c - b64d_pkg::CHAR_LOWER_A + 8'd26);
         end else if (c >= b64d_pkg::CHAR_DIGIT_0 && c <= b64d_pkg::CHAR_DIGIT_9) begin
            v = 6'(c - b64d_pkg::CHAR_DIGIT_0 + 8'd52);
         end else if (c == b64d_pkg::CHAR_PLUS) begin
            v = 6'd62;
         end else if (c == b64d_pkg::CHAR_SLASH) begin
            v = 6'd63;
         end else if (c != b64d_pkg::CHAR_PAD) begin
            return 1'b0;
         end
         return 1'b1;
      endfunction

      // Notes an accepted character and queues whatever words it causes.
      function void note_char(input logic [7:0] c);
         logic [5:0]  v;
         logic [23:0] grp;
         chars_seen++;
         if (!lookup(c, v)) begin
            // An illegal character drops the partial group.
            due_words.push_back('{8'h00, 1'b1, 1'b1});
            sextets = '0;
            held    = '0;
            bad_seen++;
            return;
         end
         if (held != 2'd3) begin
            sextets = {sextets[11:0], v};
            held    = held + 2'd1;
            return;
         end
         grp = {sextets, v};
         due_words.push_back('{grp[23:16], 1'b0, 1'b0});
         due_words.push_back('{grp[15:8], 1'b0, 1'b0});
         due_words.push_back('{grp[7:0], 1'b1, 1'b0});
         sextets = '0;
         held    = '0;
         groups_seen++;
      endfunction

      // Compares one accepted response word with the oldest one owed.
      function void check_word(input logic [7:0] data, input logic is_last,
                               input logic bad);
         decoded_word_type want;
         words_seen++;
         if (due_words.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("[%0t] unexpected word: data=%02h last=%b bad=%b",
                        $realtime, data, is_last, bad);
            return;
         end
         want = due_words.pop_front();
         if (want.data !== data || want.is_last !== is_last || want.bad !== bad) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display({"[%0t] mismatch: expected data=%02h last=%b bad=%b,",
                         " got data=%02h last=%b bad=%b"},
                        $realtime, want.data, want.is_last, want.bad,
                        data, is_last, bad);
         end
      endfunction

      function int outstanding();
         return due_words.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_char_in;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_data_byte;
   logic       rsp_last;
   logic       rsp_bad_char;

   b64_byte_scoreboard model;
   bit                 calm;
   int unsigned        cycles;

   base64_decoder_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_in   (req_char_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_byte (rsp_data_byte),
      .rsp_last      (rsp_last),
      .rsp_bad_char  (rsp_bad_char)
   );

   // Clock: 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Every accepted response word goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         model.check_word(rsp_data_byte, rsp_last, rsp_bad_char);
   end

   // Response side: ready toggles in random bursts until the calm tail.
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (calm) begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 2) != 0);
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   // Presents one character and holds it until accepted; ends at a falling edge.
   task automatic send_char(input logic [7:0] c);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model.note_char(c);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i]);
   endtask

   // A legal text character, now and then the pad.
   function automatic logic [7:0] text_char();
      if ($urandom_range(0, 7) == 0)
         return b64d_pkg::CHAR_PAD;
      return ALPHABET[$urandom_range(0, 63)];
   endfunction

   initial begin
      int sent;
      int n;
      model       = new();
      cycles      = 0;
      calm        = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_char_in = 8'h00;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: plain groups, pads, all-ones bytes, a leading pad,
      // then illegal characters at the end of a partial group and alone.
      send_text("TWFu");
      send_text("QQ==");
      send_text("//+9");
      send_text("=A0z");
      send_text("Zz9");
      send_char(8'h00);
      send_char(8'hFF);
      send_char(8'h40);
      send_char(8'h7B);

      // Random part: mostly whole groups, with stray bytes that break them.
      sent = 0;
      while (sent < RANDOM_CHARS) begin
         if (sent >= RANDOM_CHARS - CALM_TAIL)
            calm = 1'b1;
         if ($urandom_range(0, 9) < 8) begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 4;
            repeat (n) send_char(text_char());
            sent += n;
         end else begin
            send_char(8'($urandom_range(0, 255)));
            sent++;
         end
      end
      req_valid <= 1'b0;

      // Drain, then give the block time to show any stray word.
      while (model.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Decoded %0d characters: %0d full groups and %0d illegal characters,",
               model.chars_seen, model.groups_seen, model.bad_seen);
      $display("%0d response words checked with random stalls on both channels.",
               model.words_seen);
      if (model.failures == 0 && model.outstanding() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/b64d_pkg.sv
hdl/b64d_front.sv
hdl/b64d_queue.sv
hdl/b64d_back.sv
hdl/base64_decoder_top.sv
tb/sv/base64_decoder_top_tb.sv
